// ===== design/ffv1gr_pkg.sv =====
// Shared types, constants and tables of the FFV1 Golomb-Rice sample decoder.
package ffv1gr_pkg;

  localparam int unsigned Contexts  = 1024;
  localparam int unsigned TableSets = 4;
  localparam int unsigned WinBits   = 64;
  localparam int unsigned CtxW      = $clog2(Contexts);
  localparam int unsigned SetW      = $clog2(TableSets);
  localparam int unsigned CtxAw     = CtxW + SetW;
  localparam int unsigned CtxDepth  = Contexts * TableSets;

  localparam logic [3:0] EscQ       = 4'd12;
  localparam logic [5:0] EscBase    = 6'd11;
  localparam logic [7:0] CountHalve = 8'd128;
  localparam logic [5:0] RunIdxMax  = 6'd40;
  localparam logic [5:0] KMax       = 6'd32;

  localparam logic [15:0] LineWidthRst  = 16'd1024;
  localparam logic [4:0]  SampleBitsRst = 5'd9;
  localparam logic [4:0]  SampleBitsMin = 5'd2;
  localparam logic [4:0]  SampleBitsMax = 5'd18;

  typedef enum logic [0:0] {
    REG_LINE_WIDTH  = 1'b0,
    REG_SAMPLE_BITS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        opcode;
    logic [9:0]  context_index;
    logic [1:0]  table_set;
    logic        line_start;
    logic        plane_start;
    logic [63:0] bit_window;
    logic [6:0]  bits_valid;
  } in_t;

  typedef struct packed {
    logic signed [18:0] residual;
    logic [6:0]         bits_used;
    logic               underrun;
  } out_t;

  typedef struct packed {
    logic [7:0]        cnt;
    logic [31:0]       sum_abs;
    logic signed [8:0] sum_corr;
    logic signed [7:0] bias;
  } ctx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PATH,
    ST_RUNBITS,
    ST_KSRCH,
    ST_UNARY,
    ST_SUFFIX,
    ST_CODE,
    ST_UPD1,
    ST_UPD2,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RN_DONE,
    RN_RICE,
    RN_BITS
  } run_next_e;

  typedef struct packed {
    logic accept;
    logic clear;
    logic path;
    logic runbits;
    logic kstep;
    logic unary;
    logic suffix;
    logic code;
    logic upd1;
    logic upd2;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic      in_op;
    logic      op;
    logic      clr_last;
    logic      k_done;
    logic      out_free;
    logic      bits_zero;
    run_next_e path_next;
  } sts_t;

  function automatic logic [4:0] run_log2(input logic [5:0] idx);
    logic [4:0] r;
    case (idx)
      6'd0, 6'd1, 6'd2, 6'd3:    r = 5'd0;
      6'd4, 6'd5, 6'd6, 6'd7:    r = 5'd1;
      6'd8, 6'd9, 6'd10, 6'd11:  r = 5'd2;
      6'd12, 6'd13, 6'd14, 6'd15: r = 5'd3;
      6'd16, 6'd17: r = 5'd4;
      6'd18, 6'd19: r = 5'd5;
      6'd20, 6'd21: r = 5'd6;
      6'd22, 6'd23: r = 5'd7;
      default: begin
        if (idx > RunIdxMax) r = 5'd24;
        else r = 5'(idx - 6'd16);
      end
    endcase
    return r;
  endfunction

endpackage

// ===== design/ffv1gr_ctrl.sv =====
// Sequencer of the decoder: walks one word through the datapath steps.
module ffv1gr_ctrl import ffv1gr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = sts_i.op ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = sts_i.in_op ? ST_CLEAR : ST_PATH;
      end
      ST_PATH: begin
        case (sts_i.path_next)
          RN_DONE: state_d = ST_DONE;
          RN_BITS: state_d = ST_RUNBITS;
          default: state_d = ST_KSRCH;
        endcase
      end
      ST_RUNBITS: state_d = sts_i.bits_zero ? ST_KSRCH : ST_DONE;
      ST_KSRCH: begin
        if (sts_i.k_done) state_d = ST_UNARY;
      end
      ST_UNARY:  state_d = ST_SUFFIX;
      ST_SUFFIX: state_d = ST_CODE;
      ST_CODE:   state_d = ST_UPD1;
      ST_UPD1:   state_d = ST_UPD2;
      ST_UPD2:   state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    cmd_o          = '0;
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.clear    = (state_q == ST_CLEAR);
    cmd_o.path     = (state_q == ST_PATH);
    cmd_o.runbits  = (state_q == ST_RUNBITS);
    cmd_o.kstep    = (state_q == ST_KSRCH);
    cmd_o.unary    = (state_q == ST_UNARY);
    cmd_o.suffix   = (state_q == ST_SUFFIX);
    cmd_o.code     = (state_q == ST_CODE);
    cmd_o.upd1     = (state_q == ST_UPD1);
    cmd_o.upd2     = (state_q == ST_UPD2);
    cmd_o.finish   = (state_q == ST_DONE) && sts_i.out_free;
  end

endmodule

// ===== design/ffv1gr_dpath.sv =====
// Datapath of the decoder: bit window, context store, run state and Rice arithmetic.
module ffv1gr_dpath import ffv1gr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  in_t         in_data_i,
  input  logic [15:0] line_width_i,
  input  logic [4:0]  sample_bits_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output out_t        out_data_o
);

  // Context store.
  ctx_t             mem [CtxDepth];
  ctx_t             rdata_q;
  logic [CtxAw-1:0] addr_q;
  logic [CtxAw-1:0] clr_cnt_q;
  logic             mem_we;
  logic [CtxAw-1:0] mem_waddr;
  ctx_t             mem_wdata;
  ctx_t             ctx_new;

  // Item and run state.
  logic              op_q;
  logic [63:0]       win_q;
  logic [6:0]        nv_q;
  logic [7:0]        pos_q;
  logic              under_q;
  logic              ctx_nz_q;
  logic              plus1_q;
  logic [4:0]        sbits_q;
  logic [5:0]        run_idx_q;
  logic [1:0]        run_phase_q;
  logic [25:0]       run_left_q;
  logic [15:0]       column_q;
  logic [SetW-1:0]   active_set_q;
  logic [4:0]        rcnt_q;
  logic [5:0]        k_q;
  logic [3:0]        q_q;
  logic              esc_q;
  logic [36:0]       v_q;
  logic [37:0]       code_q;
  logic signed [39:0] sc1_q;
  logic [31:0]       sa1_q;
  logic [7:0]        cnt1_q;
  logic [18:0]       res_q;
  logic signed [18:0] result_q;
  logic              out_valid_q;
  out_t              out_q;

  function automatic logic [31:0] take(input logic [63:0] w, input logic [5:0] n);
    logic [63:0] s;
    s = w >> (7'd64 - {1'b0, n});
    return s[31:0];
  endfunction

  logic [6:0]  rem;
  logic [6:0]  nv_in;
  logic [SetW-1:0] set_in;

  assign rem   = ({1'b0, nv_q} > pos_q) ? 7'(nv_q - pos_q[6:0]) : 7'd0;
  assign nv_in = (in_data_i.bits_valid > 7'(WinBits)) ? 7'(WinBits) : in_data_i.bits_valid;
  assign set_in = in_data_i.line_start ? in_data_i.table_set : active_set_q;

  // Run-mode decision for the first step of a word.
  logic        direct;
  logic [1:0]  ph;
  logic [5:0]  idx;
  logic [4:0]  tabv;
  logic [24:0] rlen;
  logic        fits;
  logic        first_bit;
  logic        run_start;
  run_next_e   path_next;

  always_comb begin
    direct    = (run_phase_q == 2'd0) && ctx_nz_q;
    ph        = (run_phase_q == 2'd0) ? 2'd1 : run_phase_q;
    idx       = (run_idx_q > RunIdxMax) ? RunIdxMax : run_idx_q;
    tabv      = run_log2(idx);
    rlen      = 25'd1 << tabv;
    fits      = (26'(column_q) + 26'(rlen)) <= 26'(line_width_i);
    first_bit = win_q[63];
    run_start = !direct && (ph == 2'd1) && (run_left_q == '0);
    if (direct) path_next = RN_RICE;
    else if (run_start) begin
      if (first_bit) path_next = RN_DONE;
      else if ((idx != 6'd0) && (tabv != 5'd0)) path_next = RN_BITS;
      else path_next = RN_RICE;
    end else if (run_left_q != '0) path_next = RN_DONE;
    else path_next = RN_RICE;
  end

  logic [31:0] rb_val;
  assign rb_val = take(win_q, {1'b0, rcnt_q});

  // Rice parameter search, one step a cycle.
  logic [39:0] kshift;
  logic        k_done;
  assign kshift = 40'(rdata_q.cnt) << k_q;
  assign k_done = (k_q == KMax) || !(kshift < 40'(rdata_q.sum_abs));

  // Unary prefix with escape.
  logic [3:0] uz;
  logic       ufound;
  logic [3:0] u_q;
  logic [3:0] u_n;
  logic       u_esc;
  logic       u_under;

  always_comb begin
    uz     = EscQ;
    ufound = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (!ufound && win_q[63-i]) begin
        uz     = 4'(i);
        ufound = 1'b1;
      end
    end
    u_esc   = 1'b0;
    u_under = 1'b0;
    if ((uz < EscQ) && (7'(uz) < rem)) begin
      u_q = uz;
      u_n = uz + 4'd1;
    end else if (rem >= 7'(EscQ)) begin
      u_q   = EscQ;
      u_n   = EscQ;
      u_esc = 1'b1;
    end else begin
      u_q     = rem[3:0];
      u_n     = rem[3:0];
      u_under = 1'b1;
    end
  end

  // Suffix field.
  logic [5:0]  s_n;
  logic [31:0] s_val;
  logic [36:0] s_v;
  always_comb begin
    s_n   = esc_q ? {1'b0, sbits_q} : k_q;
    s_val = take(win_q, s_n);
    if (esc_q) s_v = 37'(s_val) + 37'(EscBase);
    else s_v = (37'(q_q) << k_q) | 37'(s_val);
  end

  // Zigzag to signed, then sign correction from the context sums.
  logic [10:0] chk;
  logic [37:0] zz;
  logic [37:0] code_c;
  always_comb begin
    chk    = {rdata_q.sum_corr[8], rdata_q.sum_corr, 1'b0} + {3'b000, rdata_q.cnt};
    zz     = {2'b00, v_q[36:1]};
    if (v_q[0]) zz = ~zz;
    code_c = chk[10] ? ~zz : zz;
  end

  // Sum updates, bias add and count halving.
  logic signed [39:0] sc_sum;
  logic [37:0]        mag;
  logic [38:0]        sa_sum;
  logic [31:0]        sa_sat;
  logic [18:0]        res_c;
  always_comb begin
    sc_sum = 40'(rdata_q.sum_corr) + {{2{code_q[37]}}, code_q};
    mag    = code_q[37] ? (38'd0 - code_q) : code_q;
    sa_sum = 39'(rdata_q.sum_abs) + {1'b0, mag};
    sa_sat = (sa_sum[38:32] != '0) ? '1 : sa_sum[31:0];
    res_c  = code_q[18:0] + 19'(rdata_q.bias);
  end

  // Bias and correction-sum adaptation, and the wrap to the sample width.
  logic [7:0]         c2;
  logic signed [39:0] c2s;
  logic signed [39:0] sc2;
  logic signed [7:0]  bias2;
  logic signed [18:0] wrapv;
  logic               wtop;
  always_comb begin
    c2    = cnt1_q + 8'd1;
    c2s   = signed'({32'd0, c2});
    sc2   = sc1_q;
    bias2 = rdata_q.bias;
    if (sc1_q <= -c2s) begin
      if (rdata_q.bias != -8'sd128) bias2 = rdata_q.bias - 8'sd1;
      sc2 = sc1_q + c2s;
      if (sc2 <= -c2s) sc2 = 40'sd1 - c2s;
    end else if (sc1_q > 40'sd0) begin
      if (rdata_q.bias != 8'sd127) bias2 = rdata_q.bias + 8'sd1;
      if (sc1_q > c2s) sc2 = '0;
      else sc2 = sc1_q - c2s;
    end
    ctx_new.cnt      = c2;
    ctx_new.sum_abs  = sa1_q;
    ctx_new.sum_corr = sc2[8:0];
    ctx_new.bias     = bias2;
    wtop = res_q[sbits_q - 5'd1];
    for (int i = 0; i < 19; i++) begin
      wrapv[i] = (5'(i) < sbits_q) ? res_q[i] : wtop;
    end
    if (plus1_q && !wrapv[18]) wrapv = wrapv + 19'sd1;
  end

  // Bits consumed in this step.
  logic       cons_en;
  logic [5:0] cons_n;
  always_comb begin
    cons_en = 1'b0;
    cons_n  = '0;
    if (cmd_i.path && run_start) begin
      cons_en = 1'b1;
      cons_n  = 6'd1;
    end else if (cmd_i.runbits) begin
      cons_en = 1'b1;
      cons_n  = {1'b0, rcnt_q};
    end else if (cmd_i.unary) begin
      cons_en = 1'b1;
      cons_n  = {2'b00, u_n};
    end else if (cmd_i.suffix) begin
      cons_en = 1'b1;
      cons_n  = s_n;
    end
  end

  // Memory: one write port for the clearing pass and the update, one read port.
  always_comb begin
    mem_we    = cmd_i.clear || cmd_i.upd2;
    mem_waddr = cmd_i.clear ? clr_cnt_q : addr_q;
    if (cmd_i.clear) begin
      mem_wdata.cnt      = 8'd1;
      mem_wdata.sum_abs  = 32'd4;
      mem_wdata.sum_corr = '0;
      mem_wdata.bias     = '0;
    end else begin
      mem_wdata = ctx_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.accept) rdata_q <= mem[{set_in, in_data_i.context_index}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q    <= '0;
      op_q         <= 1'b0;
      run_idx_q    <= '0;
      run_phase_q  <= '0;
      run_left_q   <= '0;
      column_q     <= '0;
      active_set_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.accept) begin
        op_q <= in_data_i.opcode;
        if (!in_data_i.opcode) begin
          if (in_data_i.plane_start) run_idx_q <= '0;
          if (in_data_i.line_start) begin
            column_q     <= '0;
            run_phase_q  <= '0;
            run_left_q   <= '0;
            active_set_q <= in_data_i.table_set;
          end
        end
      end
      if (cmd_i.path && !direct) begin
        run_phase_q <= ph;
        if (run_start) begin
          if (first_bit) begin
            run_idx_q  <= (fits && (idx < RunIdxMax)) ? idx + 6'd1 : idx;
            run_left_q <= 26'(rlen - 25'd1);
          end else begin
            run_phase_q <= 2'd2;
            run_idx_q   <= (idx != 6'd0) ? idx - 6'd1 : 6'd0;
            if (!((idx != 6'd0) && (tabv != 5'd0))) begin
              run_phase_q <= '0;
              run_left_q  <= '0;
            end
          end
        end else if (run_left_q != '0) begin
          run_left_q <= run_left_q - 26'd1;
        end else begin
          run_phase_q <= '0;
          run_left_q  <= '0;
        end
      end
      if (cmd_i.runbits) begin
        if (rb_val != '0) begin
          run_left_q <= 26'(rb_val - 32'd1);
        end else begin
          run_phase_q <= '0;
          run_left_q  <= '0;
        end
      end
      if (cmd_i.finish) begin
        if (!op_q) column_q <= column_q + 16'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      win_q    <= in_data_i.bit_window & ~({WinBits{1'b1}} >> nv_in);
      nv_q     <= nv_in;
      pos_q    <= '0;
      under_q  <= 1'b0;
      ctx_nz_q <= (in_data_i.context_index != '0);
      plus1_q  <= 1'b0;
      k_q      <= '0;
      result_q <= '0;
      addr_q   <= {set_in, in_data_i.context_index};
      if (sample_bits_i < SampleBitsMin) sbits_q <= SampleBitsMin;
      else if (sample_bits_i > SampleBitsMax) sbits_q <= SampleBitsMax;
      else sbits_q <= sample_bits_i;
    end
    if (cons_en) begin
      win_q <= win_q << cons_n;
      pos_q <= pos_q + 8'(cons_n);
      if (7'(cons_n) > rem) under_q <= 1'b1;
    end
    if (cmd_i.path && !direct) begin
      if (run_start) begin
        rcnt_q <= tabv;
        if (!first_bit && !((idx != 6'd0) && (tabv != 5'd0))) plus1_q <= 1'b1;
      end else if (run_left_q == '0) begin
        plus1_q <= 1'b1;
      end
    end
    if (cmd_i.runbits && (rb_val == '0)) plus1_q <= 1'b1;
    if (cmd_i.kstep && !k_done) k_q <= k_q + 6'd1;
    if (cmd_i.unary) begin
      q_q   <= u_q;
      esc_q <= u_esc;
      if (u_under) under_q <= 1'b1;
    end
    if (cmd_i.suffix) v_q <= s_v;
    if (cmd_i.code) code_q <= code_c;
    if (cmd_i.upd1) begin
      res_q <= res_c;
      if (rdata_q.cnt == CountHalve) begin
        cnt1_q <= CountHalve >> 1;
        sa1_q  <= sa_sat >> 1;
        sc1_q  <= sc_sum >>> 1;
      end else begin
        cnt1_q <= rdata_q.cnt;
        sa1_q  <= sa_sat;
        sc1_q  <= sc_sum;
      end
    end
    if (cmd_i.upd2) result_q <= wrapv;
    if (cmd_i.finish) begin
      out_q.residual  <= result_q;
      out_q.bits_used <= (pos_q < {1'b0, nv_q}) ? pos_q[6:0] : nv_q;
      out_q.underrun  <= under_q;
    end
  end

  always_comb begin
    sts_o.in_op     = in_data_i.opcode;
    sts_o.op        = op_q;
    sts_o.clr_last  = (clr_cnt_q == CtxAw'(CtxDepth - 1));
    sts_o.k_done    = k_done;
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.bits_zero = (rb_val == '0);
    sts_o.path_next = path_next;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/ffv1gr_golomb_rice_top_placeholder.sv =====
// Configuration register bank of the decoder, read and written over APB.
module ffv1gr_regs import ffv1gr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [15:0] line_width_o,
  output logic [4:0]  sample_bits_o
);

  logic [15:0] line_width_q;
  logic [4:0]  sample_bits_q;
  reg_idx_e    sel;

  assign sel = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q  <= LineWidthRst;
      sample_bits_q <= SampleBitsRst;
    end else if (psel && penable && pwrite) begin
      case (sel)
        REG_LINE_WIDTH:  line_width_q  <= pwdata[15:0];
        REG_SAMPLE_BITS: sample_bits_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_LINE_WIDTH:  prdata = {16'd0, line_width_q};
      REG_SAMPLE_BITS: prdata = {27'd0, sample_bits_q};
      default:         prdata = '0;
    endcase
  end

  assign line_width_o  = line_width_q;
  assign sample_bits_o = sample_bits_q;

endmodule

// ===== design/ffv1_golomb_rice_sample_decoder.sv =====
// A Rice sample goes through path decision, one-step-a-cycle parameter search (k = Rice
// parameter, 0 to 32), unary prefix, suffix, code and the update steps; a run-mode sample goes
// to output from the path decision or a run-length read, or decodes Rice after a zero run length.
// One word is in work at a time; the next is taken once the result sits in the output register.
// Context store update is a read-modify-write of one 4096-entry memory per Rice-decoded sample.
// Reset and a context reset word clear all 4096 entries, no word taken meanwhile.
module ffv1_golomb_rice_sample_decoder import ffv1gr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] line_width;
  logic [4:0]  sample_bits;

  assign pready = 1'b1;

  ffv1gr_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .line_width_o  (line_width),
    .sample_bits_o (sample_bits)
  );

  ffv1gr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffv1gr_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_data_i     (in_data_i),
    .line_width_i  (line_width),
    .sample_bits_i (sample_bits),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_data_o    (out_data_o)
  );

endmodule
